FILE: rtl/ir_pulse_distance_receiver_macros.svh
// assertion macros for the ir pulse distance receiver
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef IR_PULSE_DISTANCE_RECEIVER_MACROS_SVH
`define IR_PULSE_DISTANCE_RECEIVER_MACROS_SVH

// same-cycle implication
`define IRPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("irpd assertion failed");

// next-cycle implication
`define IRPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("irpd assertion failed");

`endif

FILE: rtl/irpd_pkg.sv
// types, constants and register codes of the ir pulse distance receiver
// no dependencies
package irpd_pkg;

  localparam int BufferBytes = 64;
  localparam int BitsPerByte = 8;
  localparam int BitCap      = BufferBytes * BitsPerByte;
  localparam int BitCntW     = $clog2(BitCap + 1);
  localparam int TimeW       = 16;
  localparam int NumRegs     = 8;
  localparam int RegIdxW     = 3;
  localparam int BitIdxW     = 9;
  localparam int ByteCntW    = 7;

  typedef enum logic [RegIdxW-1:0] {
    RegPreMin   = 3'd0,
    RegPreMax   = 3'd1,
    RegLongMin  = 3'd2,
    RegLongMax  = 3'd3,
    RegShortMin = 3'd4,
    RegShortMax = 3'd5,
    RegOneMin   = 3'd6,
    RegOneMax   = 3'd7
  } reg_idx_e;

  typedef logic [NumRegs-1:0][TimeW-1:0] cfg_regs_t;

  localparam cfg_regs_t CfgReset = {
    16'd977, 16'd586, 16'd586, 16'd195, 16'd4297, 16'd2734, 16'd7812, 16'd6250
  };

  typedef enum logic [2:0] {
    PhIdle        = 3'd0,
    PhPreamble    = 3'd1,
    PhHeaderSpace = 3'd2,
    PhBitPulse    = 3'd3,
    PhBitSpace    = 3'd4
  } rx_phase_e;

  typedef enum logic {
    KindBit   = 1'b0,
    KindFrame = 1'b1
  } res_kind_e;

  typedef enum logic [2:0] {
    StSuccess = 3'd0,
    StError   = 3'd1,
    StShort   = 3'd2,
    StPartial = 3'd3,
    StNone    = 3'd4
  } frame_status_e;

  typedef struct packed {
    rx_phase_e          phase;
    logic               last_level;
    logic               expect_rising;
    logic [TimeW-1:0]   last_time;
    logic [BitCntW-1:0] bits;
  } rx_state_t;

  typedef struct packed {
    res_kind_e           kind;
    logic [BitIdxW-1:0]  bit_index;
    logic                bit_value;
    logic [ByteCntW-1:0] byte_count;
    frame_status_e       status;
    logic [TimeW-1:0]    bad_interval;
  } rx_result_t;

  localparam rx_state_t StateRestart = '{
    phase: PhIdle, last_level: 1'b1, expect_rising: 1'b0,
    last_time: '0, bits: '0
  };

endpackage

FILE: rtl/irpd_step.sv
// next-state and result logic for one pin edge of the ir receiver
// depends on irpd_pkg
module irpd_step (
  input  irpd_pkg::rx_state_t          state_i,
  input  irpd_pkg::cfg_regs_t          cfg_i,
  input  logic                         level_i,
  input  logic [irpd_pkg::TimeW-1:0]   time_i,
  output irpd_pkg::rx_state_t          state_o,
  output logic                         res_valid_o,
  output irpd_pkg::rx_result_t         res_o
);
  import irpd_pkg::*;

  logic [TimeW-1:0]   dt;
  logic               falling_ok;
  logic               rising_ok;
  logic               win_pre;
  logic               win_long;
  logic               win_short;
  logic               win_one;
  logic [BitCntW-1:0] bytes_full;
  logic [ByteCntW-1:0] bytes;
  rx_result_t         note;

  assign dt         = time_i - state_i.last_time;
  assign falling_ok = state_i.last_level & ~level_i;
  assign rising_ok  = ~state_i.last_level & level_i;
  assign win_pre    = (dt >= cfg_i[RegPreMin]) && (dt <= cfg_i[RegPreMax]);
  assign win_long   = (dt >= cfg_i[RegLongMin]) && (dt <= cfg_i[RegLongMax]);
  assign win_short  = (dt >= cfg_i[RegShortMin]) && (dt <= cfg_i[RegShortMax]);
  assign win_one    = (dt >= cfg_i[RegOneMin]) && (dt <= cfg_i[RegOneMax]);
  assign bytes_full = (state_i.bits >> $clog2(BitsPerByte))
                    + BitCntW'(|state_i.bits[$clog2(BitsPerByte)-1:0]);
  assign bytes      = bytes_full[ByteCntW-1:0];

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    note        = '{kind: KindFrame, bit_index: '0, bit_value: 1'b0,
                    byte_count: '0, status: StError, bad_interval: '0};
    res_o       = note;
    if (level_i == state_i.expect_rising) begin
      case (state_i.phase)
        PhPreamble: begin
          if (!rising_ok) begin
            state_o = StateRestart;
          end else if (win_pre) begin
            state_o.phase = PhHeaderSpace;
          end else begin
            res_valid_o      = 1'b1;
            res_o.byte_count = bytes;
            state_o          = StateRestart;
          end
        end
        PhHeaderSpace: begin
          if (!falling_ok) begin
            state_o = StateRestart;
          end else if (win_long) begin
            state_o.phase = PhBitPulse;
          end else begin
            res_valid_o  = 1'b1;
            res_o.status = StShort;
            state_o      = StateRestart;
          end
        end
        PhBitPulse: begin
          if (rising_ok) begin
            if (win_short) begin
              state_o.phase = PhBitSpace;
            end else begin
              res_valid_o        = 1'b1;
              res_o.byte_count   = bytes;
              res_o.bad_interval = dt;
              state_o            = StateRestart;
            end
          end
        end
        PhBitSpace: begin
          if (falling_ok) begin
            if (win_one || win_short) begin
              state_o.phase = PhBitPulse;
              if (state_i.bits < BitCntW'(BitCap)) begin
                res_valid_o     = 1'b1;
                res_o.kind      = KindBit;
                res_o.bit_index = state_i.bits[BitIdxW-1:0];
                res_o.bit_value = win_one;
                res_o.status    = StSuccess;
                state_o.bits    = state_i.bits + 1'b1;
              end
            end else if (win_long) begin
              res_valid_o      = 1'b1;
              res_o.byte_count = bytes;
              res_o.status     = StSuccess;
              state_o          = StateRestart;
            end else if (state_i.bits != '0) begin
              res_valid_o        = 1'b1;
              res_o.byte_count   = bytes;
              res_o.status       = StPartial;
              res_o.bad_interval = dt;
              state_o            = StateRestart;
            end else begin
              res_valid_o  = 1'b1;
              res_o.status = StNone;
              state_o      = StateRestart;
            end
          end
        end
        default: begin
          if (falling_ok) begin
            state_o.phase = PhPreamble;
          end else begin
            res_valid_o      = 1'b1;
            res_o.byte_count = bytes;
            state_o          = StateRestart;
          end
        end
      endcase
      if (state_o.phase != PhIdle) begin
        state_o.last_level    = level_i;
        state_o.last_time     = time_i;
        state_o.expect_rising = ~level_i;
      end
    end
  end

endmodule

FILE: rtl/ir_pulse_distance_receiver.sv
// Pulse-distance infrared receiver. Each input item is one pin edge (level after the edge and
// a 16-bit tick timestamp); the decoder checks preamble, header space and per-bit pulse/space
// windows, emits one item per stored data bit and one frame notification at frame end.
// An edge lands in the input register, is decoded into the result register once the output
// is free and any item it yields is then offered; edges run back to back at one per cycle while the
// output is not stalled, and a result held by a stalled output blocks the next edge.
module ir_pulse_distance_receiver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [irpd_pkg::RegIdxW-1:0]      cfg_index_i,
  input  logic [irpd_pkg::TimeW-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // pin_level, edge_time[15:0], pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,  // bit_index[8:0], bit_value,
                                                           // byte_count[6:0], frame_status[2:0],
                                                           // bad_interval[15:0], pad
  output logic                              m_axis_tuser   // result_kind
);
  import irpd_pkg::*;

  `include "ir_pulse_distance_receiver_macros.svh"

  cfg_regs_t        cfg_q;
  rx_state_t        state_q;
  rx_state_t        state_d;
  logic             in_valid_q;
  logic             in_level_q;
  logic [TimeW-1:0] in_time_q;
  logic             out_valid_q;
  rx_result_t       out_res_q;
  rx_result_t       res_d;
  logic             res_valid_d;
  logic             process;
  logic             s_accept;

  assign cfg_ready_o   = 1'b1;
  assign process       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | process;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  irpd_step u_step (
    .state_i     (state_q),
    .cfg_i       (cfg_q),
    .level_i     (in_level_q),
    .time_i      (in_time_q),
    .state_o     (state_d),
    .res_valid_o (res_valid_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateRestart;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (process) begin
        in_valid_q <= 1'b0;
      end
      if (process) begin
        state_q <= state_d;
      end
      if (process && res_valid_d) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_level_q <= s_axis_tdata[0];
      in_time_q  <= s_axis_tdata[TimeW:1];
    end
    if (process && res_valid_d) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tdata  = {4'b0, out_res_q.bad_interval, out_res_q.status,
                          out_res_q.byte_count, out_res_q.bit_value, out_res_q.bit_index};

  `IRPD_ASSERT_IMPL(a_bits_cap, 1'b1, state_q.bits <= BitCntW'(BitCap))
  `IRPD_ASSERT_IMPL(a_idle_clear, state_q.phase == PhIdle, state_q.bits == '0)
  `IRPD_ASSERT_IMPL(a_dir_track, 1'b1, state_q.expect_rising == ~state_q.last_level)
  `IRPD_ASSERT_NEXT(a_frame_restart, process && res_valid_d && res_d.kind == KindFrame,
                    state_q.phase == PhIdle && m_axis_tvalid)

endmodule
